@@ hw/rtl/rpm_pkg.sv @@
// ----------------------------------------------------------------------------
// rpm_pkg
// Types, constants and rounding helpers shared by the revolve profile mesh.
// ----------------------------------------------------------------------------
package rpm_pkg;

  localparam int MaxPoints = 64;
  localparam int MaxSlices = 64;
  localparam int PointAw   = $clog2(MaxPoints);

  localparam logic [1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [1:0] CFG_SLICE_COUNT = 2'd1;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  localparam logic [31:0] SC1 = 32'd1686629713;
  localparam logic [31:0] SC3 = 32'd693598669;
  localparam logic [31:0] SC5 = 32'd85569306;
  localparam logic [31:0] SC7 = 32'd5026995;
  localparam logic [31:0] SC9 = 32'd172273;
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;

  typedef struct packed {
    logic               load;
    logic [5:0]         pidx;
    logic [5:0]         sidx;
    logic [6:0]         np;
    logic [6:0]         ns;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } item_t;

  typedef struct packed {
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic signed [15:0] vert_z;
    logic signed [17:0] norm_x;
    logic signed [17:0] norm_y;
    logic signed [17:0] norm_z;
    logic [11:0]        idx_next_here;
    logic [11:0]        idx_this_below;
    logic [11:0]        idx_this_here;
    logic [11:0]        idx_next_below;
    logic               tris_valid;
  } res_t;

  function automatic logic signed [15:0] rnd_sat16(input logic signed [35:0] v);
    logic signed [35:0] t;
    logic signed [20:0] sh;
    t  = v + 36'sd16384;
    sh = 21'(t >>> 15);
    if (sh > 21'sd32767) begin
      return 16'sh7fff;
    end else if (sh < -21'sd32768) begin
      return 16'sh8000;
    end
    return 16'(sh);
  endfunction

  function automatic logic signed [17:0] rnd_sat18(input logic signed [35:0] v);
    logic signed [35:0] t;
    logic signed [20:0] sh;
    t  = v + 36'sd16384;
    sh = 21'(t >>> 15);
    if (sh > 21'sd131071) begin
      return 18'sh1ffff;
    end else if (sh < -21'sd131072) begin
      return 18'sh20000;
    end
    return 18'(sh);
  endfunction

endpackage

@@ hw/rtl/rpm_ram.sv @@
// ----------------------------------------------------------------------------
// rpm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/rpm_fifo.sv @@
// ----------------------------------------------------------------------------
// rpm_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module rpm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ hw/rtl/rpm_front.sv @@
// ----------------------------------------------------------------------------
// rpm_front
// Configuration registers; classify and filter incoming transactions.
// ----------------------------------------------------------------------------
module rpm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [6:0]          cfg_data_i,
  input  logic                push_i,
  input  logic                full_i,
  input  logic                action_i,
  input  logic [5:0]          point_index_i,
  input  logic [5:0]          slice_index_i,
  input  logic signed [15:0]  profile_x_i,
  input  logic signed [15:0]  profile_y_i,
  output logic                push_o,
  output rpm_pkg::item_t      item_o
);
  import rpm_pkg::*;

  logic [6:0] np_q, ns_q;
  logic [6:0] np, ns;
  logic       keep;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q <= 7'd8;
      ns_q <= 7'd8;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_POINT_COUNT: np_q <= cfg_data_i;
        CFG_SLICE_COUNT: ns_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    np = (np_q < 7'd2) ? 7'd2 : ((np_q > 7'(MaxPoints)) ? 7'(MaxPoints) : np_q);
    ns = (ns_q < 7'd2) ? 7'd2 : ((ns_q > 7'(MaxSlices)) ? 7'(MaxSlices) : ns_q);
    keep = !action_i || (({1'b0, point_index_i} < np) && ({1'b0, slice_index_i} < ns));
    item_o.load = !action_i;
    item_o.pidx = point_index_i;
    item_o.sidx = slice_index_i;
    item_o.np   = np;
    item_o.ns   = ns;
    item_o.px   = profile_x_i;
    item_o.py   = profile_y_i;
  end

  assign push_o = push_i && !full_i && keep;

endmodule

@@ hw/rtl/rpm_qsin.sv @@
// ----------------------------------------------------------------------------
// rpm_qsin
// Six stage quarter wave sine: Taylor series in Q30, result in Q1.15.
// ----------------------------------------------------------------------------
module rpm_qsin (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] x_i,
  output logic [15:0] s_o
);
  import rpm_pkg::*;

  logic [31:0] x_q  [1:5];
  logic [31:0] x2_q [1:5];
  logic [31:0] p_q  [2:5];
  logic [15:0] s_q;
  logic [31:0] sv;
  logic [16:0] rv;

  always_comb begin
    sv = 32'((64'(p_q[5]) * 64'(x_q[5])) >> 30);
    rv = 17'((33'(sv) + 33'd16384) >> 15);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[1]  <= x_i;
      x2_q[1] <= 32'((64'(x_i) * 64'(x_i)) >> 30);
      for (int k = 2; k <= 5; k++) begin
        x_q[k]  <= x_q[k-1];
        x2_q[k] <= x2_q[k-1];
      end
      p_q[2] <= SC7 - 32'((64'(SC9) * 64'(x2_q[1])) >> 30);
      p_q[3] <= SC5 - 32'((64'(p_q[2]) * 64'(x2_q[2])) >> 30);
      p_q[4] <= SC3 - 32'((64'(p_q[3]) * 64'(x2_q[3])) >> 30);
      p_q[5] <= SC1 - 32'((64'(p_q[4]) * 64'(x2_q[4])) >> 30);
      s_q    <= (rv > 17'd32767) ? 16'd32767 : rv[15:0];
    end
  end

  assign s_o = s_q;

endmodule

@@ hw/rtl/rpm_back.sv @@
// ----------------------------------------------------------------------------
// rpm_back
// Execute pipeline: phase divide, sine and cosine, profile store, vertex math.
// ----------------------------------------------------------------------------
module rpm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rpm_pkg::item_t  item_i,
  input  logic            empty_i,
  output logic            pop_o,
  input  logic            full_i,
  output logic            push_o,
  output rpm_pkg::res_t   res_o
);
  import rpm_pkg::*;

  logic adv;
  assign adv   = !full_i;
  assign pop_o = adv && !empty_i;

  // phase divider: one quotient bit per stage
  logic [32:0] dv_q;
  item_t       dit_q  [0:32];
  logic [6:0]  drem_q [0:32];
  logic [31:0] dquo_q [0:32];
  logic [6:0]  rem_d  [1:32];
  logic [31:0] quo_d  [1:32];
  logic [6:0]  sp1_in, rem0;

  always_comb begin
    logic [31:0] half;
    logic [7:0]  trial;
    logic        ge;
    sp1_in = {1'b0, item_i.sidx} + 7'd1;
    rem0   = (sp1_in >= item_i.ns) ? sp1_in - item_i.ns : sp1_in;
    for (int k = 1; k <= 32; k++) begin
      half     = {26'd0, dit_q[k-1].ns[6:1]};
      trial    = {drem_q[k-1], half[32-k]};
      ge       = (trial >= {1'b0, dit_q[k-1].ns});
      rem_d[k] = ge ? 7'(trial - {1'b0, dit_q[k-1].ns}) : trial[6:0];
      quo_d[k] = {dquo_q[k-1][30:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dit_q[0]  <= item_i;
      drem_q[0] <= rem0;
      dquo_q[0] <= '0;
      for (int k = 1; k <= 32; k++) begin
        dit_q[k]  <= dit_q[k-1];
        drem_q[k] <= rem_d[k];
        dquo_q[k] <= quo_d[k];
      end
    end
  end

  // sine and cosine
  logic [31:0] phase, xa, xb;
  logic [15:0] qa, qb;
  logic [6:1]  sv_q;
  item_t       sit_q   [1:6];
  logic [1:0]  squad_q [1:6];

  assign phase = dquo_q[32];
  assign xa    = {2'b00, phase[29:0]};
  assign xb    = Q30_ONE - xa;

  rpm_qsin u_sin_a (.clk_i(clk_i), .en_i(adv), .x_i(xa), .s_o(qa));
  rpm_qsin u_sin_b (.clk_i(clk_i), .en_i(adv), .x_i(xb), .s_o(qb));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sit_q[1]   <= dit_q[32];
      squad_q[1] <= phase[31:30];
      for (int k = 2; k <= 6; k++) begin
        sit_q[k]   <= sit_q[k-1];
        squad_q[k] <= squad_q[k-1];
      end
    end
  end

  // profile store, three read copies for point, previous and next
  logic                 st_we;
  logic [PointAw-1:0]   a_here, a_prev, a_next;
  logic [31:0]          st_wdata, rd_here, rd_prev, rd_next;

  assign st_we    = adv && sv_q[5] && sit_q[5].load;
  assign a_here   = PointAw'(sit_q[5].pidx);
  assign a_prev   = a_here - PointAw'(1);
  assign a_next   = a_here + PointAw'(1);
  assign st_wdata = {sit_q[5].px, sit_q[5].py};

  rpm_ram #(.WIDTH(32), .DEPTH(MaxPoints)) u_ram_here (
    .clk_i(clk_i), .we_i(st_we), .waddr_i(a_here), .wdata_i(st_wdata),
    .re_i(adv), .raddr_i(a_here), .rdata_o(rd_here));
  rpm_ram #(.WIDTH(32), .DEPTH(MaxPoints)) u_ram_prev (
    .clk_i(clk_i), .we_i(st_we), .waddr_i(a_here), .wdata_i(st_wdata),
    .re_i(adv), .raddr_i(a_prev), .rdata_o(rd_prev));
  rpm_ram #(.WIDTH(32), .DEPTH(MaxPoints)) u_ram_next (
    .clk_i(clk_i), .we_i(st_we), .waddr_i(a_here), .wdata_i(st_wdata),
    .re_i(adv), .raddr_i(a_next), .rdata_o(rd_next));

  // normal, rotation select, index bases
  logic signed [16:0] sn, cs, ea, eb;
  logic signed [17:0] nx, ny, pxe, pye;
  logic               has_next, has_prev, last;
  logic [6:0]         sp1;
  logic [12:0]        thisb;
  logic [13:0]        nextb;

  always_comb begin
    ea = signed'({1'b0, qa});
    eb = signed'({1'b0, qb});
    case (squad_q[6])
      QUAD_I: begin
        sn = ea;
        cs = eb;
      end
      QUAD_II: begin
        sn = eb;
        cs = -ea;
      end
      QUAD_III: begin
        sn = -ea;
        cs = -eb;
      end
      default: begin
        sn = -eb;
        cs = ea;
      end
    endcase
    pxe      = 18'(signed'(rd_here[31:16]));
    pye      = 18'(signed'(rd_here[15:0]));
    has_next = (({1'b0, sit_q[6].pidx}) + 7'd1) < sit_q[6].np;
    has_prev = (sit_q[6].pidx != 6'd0);
    nx = '0;
    ny = '0;
    if (has_next) begin
      nx = nx - (18'(signed'(rd_next[15:0])) - pye);
      ny = ny + (18'(signed'(rd_next[31:16])) - pxe);
    end
    if (has_prev) begin
      nx = nx - (pye - 18'(signed'(rd_prev[15:0])));
      ny = ny + (pxe - 18'(signed'(rd_prev[31:16])));
    end
    sp1   = {1'b0, sit_q[6].sidx} + 7'd1;
    last  = (sp1 == sit_q[6].ns);
    thisb = {7'd0, sit_q[6].sidx} * {6'd0, sit_q[6].np};
    nextb = last ? 14'd0 : ({7'd0, sp1} * {7'd0, sit_q[6].np});
  end

  logic               v7_q, v8_q;
  logic signed [16:0] sn_q, cs_q;
  logic signed [15:0] px7_q, py7_q, py8_q;
  logic signed [17:0] nx_q, ny7_q, ny8_q;
  logic [12:0]        thisb_q;
  logic [13:0]        nextb_q;
  logic [5:0]         j_q;
  logic               tv7_q, tv8_q;
  logic signed [35:0] mxs_q, mxc_q, mns_q, mnc_q;
  logic [11:0]        i_nh_q, i_tb_q, i_th_q, i_nb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
      sv_q <= '0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (adv) begin
      dv_q    <= {dv_q[31:0], !empty_i};
      sv_q[1] <= dv_q[32];
      sv_q[5:2] <= sv_q[4:1];
      sv_q[6] <= sv_q[5] && !sit_q[5].load;
      v7_q    <= sv_q[6];
      v8_q    <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sn_q    <= sn;
      cs_q    <= cs;
      px7_q   <= rd_here[31:16];
      py7_q   <= rd_here[15:0];
      nx_q    <= nx;
      ny7_q   <= ny;
      thisb_q <= thisb;
      nextb_q <= nextb;
      j_q     <= sit_q[6].pidx;
      tv7_q   <= has_next;
      mxs_q   <= 36'(px7_q) * 36'(sn_q);
      mxc_q   <= 36'(px7_q) * 36'(cs_q);
      mns_q   <= 36'(nx_q) * 36'(sn_q);
      mnc_q   <= 36'(nx_q) * 36'(cs_q);
      py8_q   <= py7_q;
      ny8_q   <= ny7_q;
      tv8_q   <= tv7_q;
      i_nh_q  <= tv7_q ? 12'(nextb_q + {8'd0, j_q}) : 12'd0;
      i_tb_q  <= tv7_q ? 12'({1'b0, thisb_q} + {8'd0, j_q} + 14'd1) : 12'd0;
      i_th_q  <= tv7_q ? 12'({1'b0, thisb_q} + {8'd0, j_q}) : 12'd0;
      i_nb_q  <= tv7_q ? 12'(nextb_q + {8'd0, j_q} + 14'd1) : 12'd0;
    end
  end

  assign push_o = adv && v8_q;

  always_comb begin
    res_o.vert_x         = rnd_sat16(mxs_q);
    res_o.vert_y         = py8_q;
    res_o.vert_z         = rnd_sat16(mxc_q);
    res_o.norm_x         = rnd_sat18(mns_q);
    res_o.norm_y         = ny8_q;
    res_o.norm_z         = rnd_sat18(mnc_q);
    res_o.idx_next_here  = i_nh_q;
    res_o.idx_this_below = i_tb_q;
    res_o.idx_this_here  = i_th_q;
    res_o.idx_next_below = i_nb_q;
    res_o.tris_valid     = tv8_q;
  end

endmodule

@@ hw/rtl/revolve_profile_mesh.sv @@
// ----------------------------------------------------------------------------
// revolve_profile_mesh
// Surface of revolution tessellator over a stored Q7.8 profile.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle and returns one result per cycle while the
// result side pops. A generate transaction passes the 33 stage bit-serial
// phase divider, the six stage sine units and the vertex math stages on its
// way to the result queue. Loads and out-of-range generates produce no result;
// loads update the profile store in order with generates, so a generate pushed
// right after a load sees it. Profile entries never loaded since reset read
// back undefined.
module revolve_profile_mesh (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic               action_i,
  input  logic [5:0]         point_index_i,
  input  logic [5:0]         slice_index_i,
  input  logic signed [15:0] profile_x_i,
  input  logic signed [15:0] profile_y_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] vert_x_o,
  output logic signed [15:0] vert_y_o,
  output logic signed [15:0] vert_z_o,
  output logic signed [17:0] norm_x_o,
  output logic signed [17:0] norm_y_o,
  output logic signed [17:0] norm_z_o,
  output logic [11:0]        idx_next_here_o,
  output logic [11:0]        idx_this_below_o,
  output logic [11:0]        idx_this_here_o,
  output logic [11:0]        idx_next_below_o,
  output logic               tris_valid_o
);
  import rpm_pkg::*;

  item_t f_item, m_item;
  res_t  b_res, o_res;
  logic  mid_push, mid_full, mid_pop, mid_empty;
  logic  out_push, out_full;

  rpm_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .push_i(push), .full_i(mid_full),
    .action_i(action_i), .point_index_i(point_index_i),
    .slice_index_i(slice_index_i), .profile_x_i(profile_x_i),
    .profile_y_i(profile_y_i),
    .push_o(mid_push), .item_o(f_item));

  assign full = mid_full;

  rpm_fifo #(.WIDTH($bits(item_t)), .DEPTH(4)) u_mid_q (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push_i(mid_push), .wdata_i(f_item), .full_o(mid_full),
    .pop_i(mid_pop), .rdata_o(m_item), .empty_o(mid_empty));

  rpm_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .item_i(m_item), .empty_i(mid_empty), .pop_o(mid_pop),
    .full_i(out_full), .push_o(out_push), .res_o(b_res));

  rpm_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_out_q (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push_i(out_push), .wdata_i(b_res), .full_o(out_full),
    .pop_i(pop), .rdata_o(o_res), .empty_o(empty));

  assign vert_x_o         = o_res.vert_x;
  assign vert_y_o         = o_res.vert_y;
  assign vert_z_o         = o_res.vert_z;
  assign norm_x_o         = o_res.norm_x;
  assign norm_y_o         = o_res.norm_y;
  assign norm_z_o         = o_res.norm_z;
  assign idx_next_here_o  = o_res.idx_next_here;
  assign idx_this_below_o = o_res.idx_this_below;
  assign idx_this_here_o  = o_res.idx_this_here;
  assign idx_next_below_o = o_res.idx_next_below;
  assign tris_valid_o     = o_res.tris_valid;

`ifndef SYNTH
  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_push && out_full)) else $error("result written into full queue");
  a_mid_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mid_push && mid_full)) else $error("transaction written into full queue");
  a_mid_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !mid_empty) else $error("execute side popped empty queue");
`endif

endmodule
